### design/lkt_pkg.sv
// ----------------------------------------------------------------------------
// lkt_pkg
// Shared constants and types for the LRU key tracker.
// ----------------------------------------------------------------------------
package lkt_pkg;

	localparam int unsigned LKT_DEPTH    = 16;
	localparam int unsigned LKT_KEY_BITS = 16;
	localparam int unsigned CAP_BITS     = 5;
	localparam int unsigned CAP_RESET    = 16;
	localparam int unsigned IO_KEY_BITS  = 16;

	// per-cell control from the tracker's sequencer
	typedef struct packed {
		logic load;  // a touch is accepted this cycle
		logic live;  // cell holds a key of the list
		logic tap;   // cell is the current tail read out for eviction
	} cell_ctl_t;

endpackage

### design/lkt_cell.sv
// ----------------------------------------------------------------------------
// lkt_cell
// One slot of the recency list: holds a key, compares it with the touched
// key, takes its neighbor's key on a move-to-front shift.
// ----------------------------------------------------------------------------
module lkt_cell #(
	parameter int unsigned KEY_BITS = lkt_pkg::LKT_KEY_BITS
) (
	input  logic                clk,
	input  lkt_pkg::cell_ctl_t  ctl,
	input  logic [KEY_BITS-1:0] touch_key,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic                hit_in,
	input  logic [KEY_BITS-1:0] tap_in,
	output logic [KEY_BITS-1:0] key,
	output logic                hit_out,
	output logic [KEY_BITS-1:0] tap_out
);
	import lkt_pkg::*;

	logic [KEY_BITS-1:0] key_q;

	assign key     = key_q;
	assign hit_out = hit_in | (ctl.live & (key_q == touch_key));
	assign tap_out = tap_in | (ctl.tap ? key_q : '0);

	// shift unless the touched key was found nearer the front
	always_ff @(posedge clk) begin
		if (ctl.load && !hit_in) begin
			key_q <= prev_key;
		end
	end

endmodule

### design/lru_key_tracker_with_eviction_top.sv
// ----------------------------------------------------------------------------
// lru_key_tracker_with_eviction_top
// Move-to-front recency list of keys with tail eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one touch request per transfer: the key.
//   Master stream (m_*) returns one or more results per touch. m_tlast
//   marks the final result of a touch; m_tuser says the result reports an
//   evicted key.
//   cfg_we/cfg_wdata write the capacity register; write it only while idle.
// Timing:
//   The list is a row of DEPTH cells. A touch is compared against all cells
//   at once and the cells shift toward the tail in the accept cycle.
//   A touch that evicts nothing yields its result in the cycle after accept,
//   and a new touch is taken every cycle while the output keeps up.
//   A touch that evicts keys enters the run state, which reads out one
//   eviction per cycle from the tail while the output keeps up; no touch is taken then.
// Reset: list empty, capacity 16, no result pending. Cell contents are
//   not cleared; only cells below the entry count are ever used.
// Stall: results sit in the output register; while one is held and
//   m_tready is low, no touch is accepted and the eviction run pauses.
// ----------------------------------------------------------------------------
module lru_key_tracker_with_eviction_top #(
	parameter int unsigned DEPTH    = lkt_pkg::LKT_DEPTH,
	parameter int unsigned KEY_BITS = lkt_pkg::LKT_KEY_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// touch requests
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lkt_pkg::IO_KEY_BITS-1:0] s_tdata,  // [15:0] touch_key
	// results
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [0] was_present, [16:1] evicted_key
	output logic                         m_tuser,   // [0] evicted_valid
	output logic                         m_tlast,   // last_of_run
	// capacity register
	input  logic                         cfg_we,
	input  logic [lkt_pkg::CAP_BITS-1:0] cfg_wdata
);
	import lkt_pkg::*;

	// count holds up to DEPTH+1 right after a full-list insert
	localparam int unsigned CW = $clog2(DEPTH + 2);
	localparam int unsigned WW = (CW > CAP_BITS) ? CW : CAP_BITS;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                  state_q;
	logic [CAP_BITS-1:0]     capacity_q;
	logic [CW-1:0]           cnt_q;
	logic                    present_q;
	logic [KEY_BITS-1:0]     spill_q;
	logic                    m_tvalid_q;
	logic                    was_present_q;
	logic                    evicted_valid_q;
	logic [IO_KEY_BITS-1:0]  evicted_key_q;
	logic                    last_q;

	logic [KEY_BITS-1:0]     key_chain [DEPTH+1];
	logic                    hit_chain [DEPTH+1];
	logic [KEY_BITS-1:0]     tap_chain [DEPTH+1];
	cell_ctl_t               ctl [DEPTH];

	logic [KEY_BITS+IO_KEY_BITS-1:0] in_ext;
	logic [KEY_BITS+IO_KEY_BITS-1:0] out_ext;
	logic [KEY_BITS-1:0]     touch_key;
	logic [WW-1:0]           cap_w;
	logic [WW-1:0]           cap_clamped;
	logic [CW-1:0]           cap_eff;
	logic                    out_free;
	logic                    accept;
	logic                    present;
	logic [CW-1:0]           new_cnt;
	logic [CW-1:0]           tail_idx;
	logic [KEY_BITS-1:0]     tail_key;

	// key resized to the list width
	assign in_ext    = {{KEY_BITS{1'b0}}, s_tdata};
	assign touch_key = in_ext[KEY_BITS-1:0];

	// capacity clamped to 1..DEPTH
	assign cap_w = WW'(capacity_q);
	always_comb begin
		if (cap_w == '0) begin
			cap_clamped = WW'(1);
		end else if (cap_w > WW'(DEPTH)) begin
			cap_clamped = WW'(DEPTH);
		end else begin
			cap_clamped = cap_w;
		end
	end
	assign cap_eff = cap_clamped[CW-1:0];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// cell row: front gets the touched key, hit and tail tap ripple along
	assign key_chain[0] = touch_key;
	assign hit_chain[0] = 1'b0;
	assign tap_chain[0] = '0;
	assign tail_idx     = cnt_q - CW'(1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i] = '{load: accept, live: (CW'(i) < cnt_q), tap: (CW'(i) == tail_idx)};

		lkt_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.touch_key (touch_key),
			.prev_key  (key_chain[i]),
			.hit_in    (hit_chain[i]),
			.tap_in    (tap_chain[i]),
			.key       (key_chain[i+1]),
			.hit_out   (hit_chain[i+1]),
			.tap_out   (tap_chain[i+1])
		);
	end

	assign present = hit_chain[DEPTH];
	assign new_cnt = present ? cnt_q : cnt_q + CW'(1);

	// tail beyond the last cell is the key pushed out on a full insert
	assign tail_key = (cnt_q == CW'(DEPTH + 1)) ? spill_q : tap_chain[DEPTH];
	assign out_ext  = {{IO_KEY_BITS{1'b0}}, tail_key};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			capacity_q      <= CAP_BITS'(CAP_RESET);
			cnt_q           <= '0;
			present_q       <= 1'b0;
			m_tvalid_q      <= 1'b0;
			was_present_q   <= 1'b0;
			evicted_valid_q <= 1'b0;
			evicted_key_q   <= '0;
			last_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q     <= new_cnt;
						present_q <= present;
						if (new_cnt > cap_eff) begin
							state_q    <= ST_RUN;
							m_tvalid_q <= 1'b0;
						end else begin
							m_tvalid_q      <= 1'b1;
							was_present_q   <= present;
							evicted_valid_q <= 1'b0;
							evicted_key_q   <= '0;
							last_q          <= 1'b1;
						end
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (out_free) begin
						m_tvalid_q      <= 1'b1;
						was_present_q   <= present_q;
						evicted_valid_q <= 1'b1;
						evicted_key_q   <= out_ext[IO_KEY_BITS-1:0];
						last_q          <= (tail_idx == cap_eff);
						cnt_q           <= tail_idx;
						if (tail_idx == cap_eff) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload only: key shifted out of the last cell on insert
	always_ff @(posedge clk) begin
		if (accept && !present) begin
			spill_q <= key_chain[DEPTH];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, evicted_key_q, was_present_q};
	assign m_tuser  = evicted_valid_q;
	assign m_tlast  = last_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the LRU key tracker against a move-to-front list kept in the bench.
// Directed touches cover the empty, full and shrunk list. Random phases then
// run several capacity settings with gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

	import lkt_pkg::*;

	// one result as seen on the master stream
	typedef struct packed {
		logic        present;
		logic        ev_valid;
		logic [15:0] ev_key;
		logic        last;
	} lru_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [23:0]         m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                cfg_we    = 1'b0;
	logic [CAP_BITS-1:0] cfg_wdata = '0;

	// touch requests waiting for the driver, results waiting for the DUT
	logic [15:0] touch_queue[$];
	lru_result_t result_queue[$];

	// shadow of the tracker: recency order, most recent first
	logic [15:0]         mru_keys[LKT_DEPTH];
	int                  mru_count;
	logic [CAP_BITS-1:0] cap_shadow;

	int touches_sent;     // queued by the stimulus process
	int touches_accepted; // taken by the DUT
	int touches_done;     // last result of the touch consumed
	int errors;

	always #4 clk = ~clk;

	lru_key_tracker_with_eviction_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Move-to-front on the shadow list, then trim the tail down to the
	// effective capacity. Evictions come out oldest first.
	task automatic predict_touch(input logic [15:0] key);
		logic [15:0] order[$];
		int          hit;
		int          keep;
		logic        present;
		lru_result_t r;
		hit = -1;
		for (int i = 0; i < mru_count; i++)
			if (hit < 0 && mru_keys[i] == key)
				hit = i;
		present = (hit >= 0);
		order = {order, key};
		for (int i = 0; i < mru_count; i++)
			if (i != hit)
				order = {order, mru_keys[i]};
		// zero acts as one, anything past the list size as the list size
		keep = (cap_shadow == 0) ? 1 : (cap_shadow > LKT_DEPTH) ? LKT_DEPTH : cap_shadow;
		if (order.size() <= keep) begin
			r = '{present: present, ev_valid: 1'b0, ev_key: '0, last: 1'b1};
			result_queue = {result_queue, r};
		end
		while (order.size() > keep) begin
			r.present  = present;
			r.ev_valid = 1'b1;
			r.ev_key   = order.pop_back();
			r.last     = (order.size() == keep);
			result_queue = {result_queue, r};
		end
		foreach (order[i])
			mru_keys[i] = order[i];
		mru_count = order.size();
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length with random gaps. A request stays
	// up until it is taken; the predictor runs on every accepted request.
	// ------------------------------------------------------------------
	int   burst_left;
	int   gap_left;
	logic offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_touch(s_tdata);
				touches_accepted++;
				offer = 1'b0;
			end
			if (!offer && touch_queue.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					s_tdata <= touch_queue.pop_front();
					offer   = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						// new burst; about a third run back to back
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			s_tvalid <= offer;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: the stall pattern steps through four modes in turn. Twice it holds off
	// for a long stretch so the output register fills and s_tready drops.
	// ------------------------------------------------------------------
	int rx_cycle;
	int hold_left;
	int holds_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_cycle   = 0;
			hold_left  = 0;
			holds_done = 0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && touches_accepted >= (holds_done == 0 ? 60 : 220)) begin
				hold_left = 150;
				holds_done++;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_cycle % 3 != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every accepted result against the oldest expectation.
	// ------------------------------------------------------------------
	lru_result_t got;
	lru_result_t want;

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{present: m_tdata[0], ev_valid: m_tuser, ev_key: m_tdata[16:1],
				last: m_tlast};
			if (result_queue.size() == 0) begin
				$display("%0t: result expected none actual %p", $time, got);
				errors++;
			end else begin
				want = result_queue.pop_front();
				check_field("was_present", 16'(want.present), 16'(got.present));
				check_field("evicted_valid", 16'(want.ev_valid), 16'(got.ev_valid));
				check_field("evicted_key", want.ev_key, got.ev_key);
				check_field("last_of_run", 16'(want.last), 16'(got.last));
			end
			if (m_tlast)
				touches_done++;
		end
	end

	// Watchdog: too long with nothing accepted on either side.
	int quiet_cycles;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_touch(input logic [15:0] key);
		touch_queue = {touch_queue, key};
		touches_sent++;
	endtask

	// every request answered, so the block is idle
	task automatic wait_idle();
		while (touches_done != touches_sent)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_BITS-1:0] value);
		@(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= value;
		cap_shadow = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [CAP_BITS-1:0] phase_caps[8];
	logic [15:0]         key_pool[20];
	int                  pool_n;

	initial begin
		cap_shadow = CAP_BITS'(CAP_RESET);
		mru_count  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty list, extremes of the key, hits at middle, front and tail
		queue_touch(16'h0000);
		queue_touch(16'hFFFF);
		queue_touch(16'hAAAA);
		queue_touch(16'h5555);
		queue_touch(16'hFFFF);
		queue_touch(16'hFFFF);
		queue_touch(16'h0000);
		// fill to sixteen, then a new key pushes out the tail
		for (int k = 1; k <= 12; k++)
			queue_touch(k[15:0]);
		queue_touch(16'h8001);
		// shrink to three: a hit at the front evicts thirteen keys
		wait_idle();
		set_capacity(5'd3);
		queue_touch(16'h8001);
		// capacity zero acts as one
		wait_idle();
		set_capacity(5'd0);
		queue_touch(16'h7FFE);
		queue_touch(16'h7FFE);

		// random phases: mostly keys from a small pool so hits and
		// evictions mix, the rest anywhere in the key space
		phase_caps = '{5'd1, 5'd16, 5'd31, 5'd5, 5'd0, 5'd9, 5'd2, 5'd12};
		phase_caps[5] = CAP_BITS'($urandom_range(1, 16));
		foreach (phase_caps[p]) begin
			wait_idle();
			set_capacity(phase_caps[p]);
			pool_n = $urandom_range(2, 20);
			foreach (key_pool[i])
				key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
			repeat (40) begin
				if ($urandom_range(0, 9) < 7)
					queue_touch(key_pool[$urandom_range(0, pool_n - 1)]);
				else
					queue_touch(16'($urandom_range(0, 16'hFFFF)));
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (result_queue.size() != 0) begin
			$display("%0t: %0d results expected actual none", $time, result_queue.size());
			errors++;
		end
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
